>>> rtl/imu_still_calibration_macros.svh
// assertion helpers for the calibration block
`ifndef IMU_STILL_CALIBRATION_MACROS_SVH
`define IMU_STILL_CALIBRATION_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define IMUSC_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define IMUSC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/imusc_pkg.sv
package imusc_pkg;

    // default sample width
    localparam int unsigned SAMPLE_BITS_DEF = 16;

    // configuration port
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_SAMPLE_COUNT = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_NORM_SPREAD  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_GYRO_SPREAD  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_NORM_LOW     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_NORM_HIGH    = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_OFFSET_LIMIT = 3'd5;

    // register reset values
    localparam logic [15:0] RST_SAMPLE_COUNT = 16'd6000;
    localparam logic [15:0] RST_NORM_SPREAD  = 16'd390;
    localparam logic [15:0] RST_GYRO_SPREAD  = 16'd141;
    localparam logic [15:0] RST_NORM_LOW     = 16'd5182;
    localparam logic [15:0] RST_NORM_HIGH    = 16'd5739;
    localparam logic [14:0] RST_OFFSET_LIMIT = 15'd9;

    // status of a multi-cycle serial unit
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

>>> rtl/imusc_isqrt.sv
module imusc_isqrt #(
    parameter int unsigned ROOT_W = imusc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [2*ROOT_W-1:0]      radicand,
    output imusc_pkg::unit_stat_t    stat,
    output logic [ROOT_W-1:0]        root
);

    localparam int unsigned CNT_W = $clog2(ROOT_W);

    logic [2*ROOT_W-1:0] rad_reg, rad_next;
    logic [ROOT_W:0]     rem_reg, rem_next;
    logic [ROOT_W-1:0]   root_reg, root_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [ROOT_W+2:0]   rem_shift;
    logic [ROOT_W+2:0]   trial;
    logic [ROOT_W+2:0]   rem_diff;

    // one root bit per cycle, two radicand bits shifted in
    always_comb begin
        rem_shift = {rem_reg, rad_reg[2*ROOT_W-1 -: 2]};
        trial     = {1'b0, root_reg, 2'b01};
        rem_diff  = rem_shift - trial;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CNT_W'(ROOT_W - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rad_next = {rad_reg[2*ROOT_W-3:0], 2'b00};
            if (rem_shift >= trial) begin
                rem_next  = rem_diff[ROOT_W:0];
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end else begin
                rem_next  = rem_shift[ROOT_W:0];
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign root      = root_reg;

endmodule

>>> rtl/imusc_div.sv
module imusc_div #(
    parameter int unsigned DIVIDEND_W = imusc_pkg::SAMPLE_BITS_DEF + 16,
    parameter int unsigned DIVISOR_W  = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [DIVIDEND_W-1:0]    dividend,
    input  logic [DIVISOR_W-1:0]     divisor,
    output imusc_pkg::unit_stat_t    stat,
    output logic [DIVIDEND_W-1:0]    quotient,
    output logic                     rem_nz
);

    localparam int unsigned CNT_W = $clog2(DIVIDEND_W);

    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  dsr_reg, dsr_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIVISOR_W:0]    rem_shift;
    logic [DIVISOR_W:0]    rem_diff;

    // restoring division, one quotient bit per cycle
    always_comb begin
        rem_shift = {rem_reg, quo_reg[DIVIDEND_W-1]};
        rem_diff  = rem_shift - {1'b0, dsr_reg};
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
            cnt_next  = CNT_W'(DIVIDEND_W - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (rem_shift >= {1'b0, dsr_reg}) begin
                rem_next = rem_diff[DIVISOR_W-1:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b1};
            end else begin
                rem_next = rem_shift[DIVISOR_W-1:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b0};
            end
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;
    assign rem_nz    = (rem_reg != '0);

endmodule

>>> rtl/imu_still_calibration.sv
// IMU still calibration: gyro bias estimate with a stillness check.
// Input channel (s_): one accelerometer and gyro sample per request, gyro
// validity flag on s_tuser. Output channel (m_): one result per batch, the
// mean gyro offsets and mean accel magnitude in m_tdata, pass and abort flags
// in m_tuser. Registers are written through cfg_wr_en / cfg_addr / cfg_wdata;
// the user writes them only while no batch result is in flight; the block
// itself does not enforce it. Each sample holds s_tready low until the state
// machine is back in idle, so no new sample is taken before the last is
// through: the three squares are formed bit-serially, then the root is
// taken one bit per cycle. At batch end, four bit-serial dividers form the
// means and the result is posted into the output register.
// Reset loads the register defaults, clears the sample index, sums, spread
// trackers, abort flag and last gyro values; no result is pending.
// The result sits in an output register; while the receiver stalls, samples
// of the next batch are still accepted, and only a further batch end waits
// for the output register to drain before taking new samples.
`include "imu_still_calibration_macros.svh"

module imu_still_calibration #(
    parameter int unsigned SAMPLE_BITS = imusc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
    input  logic [((6*SAMPLE_BITS+7)/8)*8-1:0]        s_tdata,
    // gyro_valid
    input  logic                                      s_tuser,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    // offset_x, offset_y, offset_z, mean_norm
    output logic [63:0]                               m_tdata,
    // calibration_ok, aborted_early
    output logic [1:0]                                m_tuser,
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    input  logic                                      cfg_wr_en,
    input  logic [imusc_pkg::CFG_ADDR_W-1:0]          cfg_addr,
    input  logic [imusc_pkg::CFG_DATA_W-1:0]          cfg_wdata
);

    import imusc_pkg::*;

    localparam int unsigned S      = SAMPLE_BITS;
    localparam int unsigned SQ_W   = 2 * SAMPLE_BITS;
    localparam int unsigned SUM_W  = SAMPLE_BITS + 16;
    localparam int unsigned CMP_W  = (SAMPLE_BITS + 2 > 17) ? SAMPLE_BITS + 2 : 17;
    localparam int unsigned CNT_W  = $clog2(SAMPLE_BITS);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_SQUARE = 8'b0000_0010,
        ST_SUM    = 8'b0000_0100,
        ST_ROOT   = 8'b0000_1000,
        ST_UPDATE = 8'b0001_0000,
        ST_CHECK  = 8'b0010_0000,
        ST_DIVIDE = 8'b0100_0000,
        ST_FINISH = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [15:0] sample_count_reg, sample_count_next;
    logic [15:0] norm_spread_reg, norm_spread_next;
    logic [15:0] gyro_spread_reg, gyro_spread_next;
    logic [15:0] norm_low_reg, norm_low_next;
    logic [15:0] norm_high_reg, norm_high_next;
    logic [14:0] offset_limit_reg, offset_limit_next;

    // per-sample working registers
    logic [S-1:0]           mplier_reg [3];
    logic [S-1:0]           mplier_next [3];
    logic [SQ_W-1:0]        mcand_reg [3];
    logic [SQ_W-1:0]        mcand_next [3];
    logic [SQ_W-1:0]        square_reg [3];
    logic [SQ_W-1:0]        square_next [3];
    logic signed [S-1:0]    gyro_in_reg [3];
    logic signed [S-1:0]    gyro_in_next [3];
    logic                   gyro_valid_reg, gyro_valid_next;
    logic [CNT_W-1:0]       sq_cnt_reg, sq_cnt_next;

    // batch state
    logic [15:0]            sample_index_reg, sample_index_next;
    logic [SUM_W-1:0]       norm_sum_reg, norm_sum_next;
    logic signed [SUM_W-1:0] gyro_sum_reg [3];
    logic signed [SUM_W-1:0] gyro_sum_next [3];
    logic [S-1:0]           norm_min_reg, norm_min_next;
    logic [S-1:0]           norm_max_reg, norm_max_next;
    logic signed [S-1:0]    gyro_min_reg [3];
    logic signed [S-1:0]    gyro_min_next [3];
    logic signed [S-1:0]    gyro_max_reg [3];
    logic signed [S-1:0]    gyro_max_next [3];
    logic signed [S-1:0]    last_gyro_reg [3];
    logic signed [S-1:0]    last_gyro_next [3];
    logic                   abort_reg, abort_next;
    logic                   neg_reg [3];
    logic                   neg_next [3];

    // output register
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [63:0]            m_tdata_reg, m_tdata_next;
    logic [1:0]             m_tuser_reg, m_tuser_next;

    // combinational helpers
    logic [S-1:0]           in_abs [3];
    logic signed [S-1:0]    lg_w [3];
    logic [CMP_W-1:0]       gyro_diff [3];
    logic [CMP_W-1:0]       norm_diff;
    logic [SUM_W-1:0]       gsum_u [3];
    logic [SUM_W-1:0]       gsum_abs [3];
    logic [SQ_W+1:0]        sq_total;
    logic [15:0]            idx_inc;
    logic [15:0]            cnt_eff;
    logic                   abort_w;
    logic                   batch_done;
    logic                   out_free;
    logic                   ok_w;
    logic [15:0]            offset_w [3];
    logic [15:0]            mean_w;

    // serial units
    logic                   sqrt_start;
    unit_stat_t             root_stat;
    logic [S-1:0]           root_val;
    logic                   div_start;
    logic [SUM_W-1:0]       div_dividend [4];
    unit_stat_t             div_stat [4];
    logic [SUM_W-1:0]       div_quo [4];
    logic                   div_rnz [4];
    logic                   div_done_all;
    logic                   div_busy_any;

    imusc_isqrt #(
        .ROOT_W   (S)
    ) u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (sq_total[SQ_W-1:0]),
        .stat     (root_stat),
        .root     (root_val)
    );

    // lane 0: magnitude sum, lanes 1 to 3: gyro sums
    for (genvar k = 0; k < 4; k++) begin : g_div
        imusc_div #(
            .DIVIDEND_W (SUM_W),
            .DIVISOR_W  (16)
        ) u_div (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .start    (div_start),
            .dividend (div_dividend[k]),
            .divisor  (cnt_eff),
            .stat     (div_stat[k]),
            .quotient (div_quo[k]),
            .rem_nz   (div_rnz[k])
        );
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // per-lane helpers
    always_comb begin
        sq_total = {2'b00, square_reg[0]} + {2'b00, square_reg[1]} + {2'b00, square_reg[2]};
        cnt_eff  = (sample_count_reg == 16'd0) ? 16'd1 : sample_count_reg;
        idx_inc  = sample_index_reg + 16'd1;
        out_free = !m_tvalid_reg || m_tready;
        norm_diff = CMP_W'(norm_max_reg) - CMP_W'(norm_min_reg);
        abort_w  = (norm_diff > CMP_W'(norm_spread_reg));
        div_done_all = 1'b1;
        div_busy_any = 1'b0;
        div_dividend[0] = norm_sum_reg;
        for (int j = 0; j < 3; j++) begin
            in_abs[j] = s_tdata[(j+1)*S-1] ? (~s_tdata[j*S +: S] + 1'b1)
                                           : s_tdata[j*S +: S];
            lg_w[j]   = gyro_valid_reg ? gyro_in_reg[j] : last_gyro_reg[j];
            gyro_diff[j] = $unsigned(CMP_W'(gyro_max_reg[j]) - CMP_W'(gyro_min_reg[j]));
            if (gyro_diff[j] > CMP_W'(gyro_spread_reg)) begin
                abort_w = 1'b1;
            end
            gsum_u[j]   = $unsigned(gyro_sum_reg[j]);
            gsum_abs[j] = gsum_u[j][SUM_W-1] ? (~gsum_u[j] + 1'b1) : gsum_u[j];
            div_dividend[j+1] = gsum_abs[j];
        end
        for (int k = 0; k < 4; k++) begin
            div_done_all = div_done_all & div_stat[k].done;
            div_busy_any = div_busy_any | div_stat[k].busy;
        end
        batch_done = abort_w || (idx_inc == 16'd0) || (idx_inc >= cnt_eff);
    end

    // result fields and pass flag from the quotients
    always_comb begin
        mean_w = (div_quo[0][SUM_W-1:16] != '0) ? 16'hFFFF : div_quo[0][15:0];
        ok_w = !abort_reg;
        if (div_quo[0] < SUM_W'(norm_low_reg)) begin
            ok_w = 1'b0;
        end
        if ((div_quo[0] > SUM_W'(norm_high_reg)) ||
            ((div_quo[0] == SUM_W'(norm_high_reg)) && div_rnz[0])) begin
            ok_w = 1'b0;
        end
        for (int j = 0; j < 3; j++) begin
            if ((div_quo[j+1] > SUM_W'(offset_limit_reg)) ||
                ((div_quo[j+1] == SUM_W'(offset_limit_reg)) && div_rnz[j+1])) begin
                ok_w = 1'b0;
            end
            if (neg_reg[j]) begin
                offset_w[j] = (div_quo[j+1] > SUM_W'(32768)) ? 16'h8000
                                                             : (~div_quo[j+1][15:0] + 16'd1);
            end else begin
                offset_w[j] = (div_quo[j+1] > SUM_W'(32767)) ? 16'h7FFF
                                                             : div_quo[j+1][15:0];
            end
        end
    end

    // control and datapath next state
    always_comb begin
        state_next        = state_reg;
        sample_count_next = sample_count_reg;
        norm_spread_next  = norm_spread_reg;
        gyro_spread_next  = gyro_spread_reg;
        norm_low_next     = norm_low_reg;
        norm_high_next    = norm_high_reg;
        offset_limit_next = offset_limit_reg;
        gyro_valid_next   = gyro_valid_reg;
        sq_cnt_next       = sq_cnt_reg;
        sample_index_next = sample_index_reg;
        norm_sum_next     = norm_sum_reg;
        norm_min_next     = norm_min_reg;
        norm_max_next     = norm_max_reg;
        abort_next        = abort_reg;
        m_tvalid_next     = m_tvalid_reg;
        m_tdata_next      = m_tdata_reg;
        m_tuser_next      = m_tuser_reg;
        sqrt_start        = 1'b0;
        div_start         = 1'b0;
        for (int j = 0; j < 3; j++) begin
            mplier_next[j]    = mplier_reg[j];
            mcand_next[j]     = mcand_reg[j];
            square_next[j]    = square_reg[j];
            gyro_in_next[j]   = gyro_in_reg[j];
            gyro_sum_next[j]  = gyro_sum_reg[j];
            gyro_min_next[j]  = gyro_min_reg[j];
            gyro_max_next[j]  = gyro_max_reg[j];
            last_gyro_next[j] = last_gyro_reg[j];
            neg_next[j]       = neg_reg[j];
        end

        // configuration writes
        if (cfg_wr_en) begin
            case (cfg_addr)
                REG_SAMPLE_COUNT: sample_count_next = cfg_wdata;
                REG_NORM_SPREAD:  norm_spread_next  = cfg_wdata;
                REG_GYRO_SPREAD:  gyro_spread_next  = cfg_wdata;
                REG_NORM_LOW:     norm_low_next     = cfg_wdata;
                REG_NORM_HIGH:    norm_high_next    = cfg_wdata;
                REG_OFFSET_LIMIT: offset_limit_next = cfg_wdata[14:0];
                default: ;
            endcase
        end

        // output register drains
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            // take a sample, load the serial squarers
            ST_IDLE: begin
                if (s_tvalid) begin
                    for (int j = 0; j < 3; j++) begin
                        mplier_next[j]  = in_abs[j];
                        mcand_next[j]   = {{S{1'b0}}, in_abs[j]};
                        square_next[j]  = '0;
                        gyro_in_next[j] = $signed(s_tdata[(3+j)*S +: S]);
                    end
                    gyro_valid_next = s_tuser;
                    sq_cnt_next     = CNT_W'(S - 1);
                    state_next      = ST_SQUARE;
                end
            end
            // one multiplier bit per cycle on each axis
            ST_SQUARE: begin
                for (int j = 0; j < 3; j++) begin
                    if (mplier_reg[j][0]) begin
                        square_next[j] = square_reg[j] + mcand_reg[j];
                    end
                    mcand_next[j]  = {mcand_reg[j][SQ_W-2:0], 1'b0};
                    mplier_next[j] = {1'b0, mplier_reg[j][S-1:1]};
                end
                if (sq_cnt_reg == '0) begin
                    state_next = ST_SUM;
                end else begin
                    sq_cnt_next = sq_cnt_reg - 1'b1;
                end
            end
            // squares summed straight into the root unit
            ST_SUM: begin
                sqrt_start = 1'b1;
                state_next = ST_ROOT;
            end
            ST_ROOT: begin
                if (root_stat.done) begin
                    state_next = ST_UPDATE;
                end
            end
            // sums and spread trackers
            ST_UPDATE: begin
                norm_sum_next = norm_sum_reg + SUM_W'(root_val);
                if (sample_index_reg == 16'd0) begin
                    norm_min_next = root_val;
                    norm_max_next = root_val;
                end else begin
                    if (root_val > norm_max_reg) norm_max_next = root_val;
                    if (root_val < norm_min_reg) norm_min_next = root_val;
                end
                for (int j = 0; j < 3; j++) begin
                    last_gyro_next[j] = lg_w[j];
                    if (gyro_valid_reg) begin
                        gyro_sum_next[j] = gyro_sum_reg[j] + SUM_W'(gyro_in_reg[j]);
                    end
                    if (sample_index_reg == 16'd0) begin
                        gyro_min_next[j] = lg_w[j];
                        gyro_max_next[j] = lg_w[j];
                    end else begin
                        if (lg_w[j] > gyro_max_reg[j]) gyro_max_next[j] = lg_w[j];
                        if (lg_w[j] < gyro_min_reg[j]) gyro_min_next[j] = lg_w[j];
                    end
                end
                state_next = ST_CHECK;
            end
            // spread limits and batch end
            ST_CHECK: begin
                sample_index_next = idx_inc;
                abort_next        = abort_w;
                if (batch_done) begin
                    div_start = 1'b1;
                    for (int j = 0; j < 3; j++) begin
                        neg_next[j] = gsum_u[j][SUM_W-1];
                    end
                    state_next = ST_DIVIDE;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIVIDE: begin
                if (div_done_all) begin
                    state_next = ST_FINISH;
                end
            end
            // hand the result over and clear the batch
            ST_FINISH: begin
                if (out_free) begin
                    m_tvalid_next     = 1'b1;
                    m_tdata_next      = {mean_w, offset_w[2], offset_w[1], offset_w[0]};
                    m_tuser_next      = {abort_reg, ok_w};
                    sample_index_next = '0;
                    norm_sum_next     = '0;
                    norm_min_next     = '0;
                    norm_max_next     = '0;
                    abort_next        = 1'b0;
                    for (int j = 0; j < 3; j++) begin
                        gyro_sum_next[j] = '0;
                        gyro_min_next[j] = '0;
                        gyro_max_next[j] = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            sample_count_reg <= RST_SAMPLE_COUNT;
            norm_spread_reg  <= RST_NORM_SPREAD;
            gyro_spread_reg  <= RST_GYRO_SPREAD;
            norm_low_reg     <= RST_NORM_LOW;
            norm_high_reg    <= RST_NORM_HIGH;
            offset_limit_reg <= RST_OFFSET_LIMIT;
            sample_index_reg <= '0;
            norm_sum_reg     <= '0;
            norm_min_reg     <= '0;
            norm_max_reg     <= '0;
            abort_reg        <= 1'b0;
            m_tvalid_reg     <= 1'b0;
            for (int j = 0; j < 3; j++) begin
                gyro_sum_reg[j]  <= '0;
                gyro_min_reg[j]  <= '0;
                gyro_max_reg[j]  <= '0;
                last_gyro_reg[j] <= '0;
            end
        end else begin
            state_reg        <= state_next;
            sample_count_reg <= sample_count_next;
            norm_spread_reg  <= norm_spread_next;
            gyro_spread_reg  <= gyro_spread_next;
            norm_low_reg     <= norm_low_next;
            norm_high_reg    <= norm_high_next;
            offset_limit_reg <= offset_limit_next;
            sample_index_reg <= sample_index_next;
            norm_sum_reg     <= norm_sum_next;
            norm_min_reg     <= norm_min_next;
            norm_max_reg     <= norm_max_next;
            abort_reg        <= abort_next;
            m_tvalid_reg     <= m_tvalid_next;
            for (int j = 0; j < 3; j++) begin
                gyro_sum_reg[j]  <= gyro_sum_next[j];
                gyro_min_reg[j]  <= gyro_min_next[j];
                gyro_max_reg[j]  <= gyro_max_next[j];
                last_gyro_reg[j] <= last_gyro_next[j];
            end
        end
        gyro_valid_reg <= gyro_valid_next;
        sq_cnt_reg     <= sq_cnt_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
        for (int j = 0; j < 3; j++) begin
            mplier_reg[j]  <= mplier_next[j];
            mcand_reg[j]   <= mcand_next[j];
            square_reg[j]  <= square_next[j];
            gyro_in_reg[j] <= gyro_in_next[j];
            neg_reg[j]     <= neg_next[j];
        end
    end

    // checks
    `IMUSC_ASSERT_NEXT(a_accept_starts_square, aclk, aresetn, s_tvalid && s_tready, state_reg == ST_SQUARE, "accepted sample did not start squaring")
    `IMUSC_ASSERT_SAME(a_root_busy_in_root, aclk, aresetn, root_stat.busy, state_reg == ST_ROOT, "root unit busy outside root phase")
    `IMUSC_ASSERT_SAME(a_div_busy_in_divide, aclk, aresetn, div_busy_any, state_reg == ST_DIVIDE, "divider busy outside divide phase")
    `IMUSC_ASSERT_NEXT(a_finish_clears_batch, aclk, aresetn, state_reg == ST_FINISH && out_free, m_tvalid && sample_index_reg == 16'd0, "result not posted or batch not cleared")

endmodule
